@@ hdl/vtpc_pkg.sv @@
// Package for the video timing prescaler calculator.
// Holds the field widths, limits, register codes and the divide-by-100 step.
// No dependencies.
package vtpc_pkg;

  // Bits of the measured period that take part in the arithmetic (17..32)
  localparam int PERIOD_BITS = 32;
  localparam int PERIOD_W    = 32;
  localparam int PCT_W       = 7;
  localparam int RES_W       = 16;
  localparam int CNT_W       = 24;
  localparam int PRE_W       = 8;
  localparam int PCLK_W      = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // period * percent, and the divide-by-100 lanes (eight bits a stage)
  localparam int PROD_W   = PERIOD_BITS + PCT_W;
  localparam int D100_BPS = 8;
  localparam int D100_STG = (PROD_W + D100_BPS - 1) / D100_BPS;
  localparam int D100_W   = D100_STG * D100_BPS;

  // resolution divider: RES_W quotient bits, two a stage
  localparam int RDIV_BPS = 2;
  localparam int RDIV_STG = RES_W / RDIV_BPS;

  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
  localparam logic [RES_W-1:0]  MIN_RES     = 16'd32;
  localparam logic [31:0]       SMALL_LIMIT = 32'h0000_ffff;
  localparam logic [31:0]       MID_LIMIT   = 32'h000f_ffff;
  localparam logic [PRE_W-1:0]  PRE_NONE    = 8'h00;
  localparam logic [PRE_W-1:0]  PRE_MID     = 8'h0f;
  localparam logic [PRE_W-1:0]  PRE_HIGH    = 8'hff;
  localparam logic [PCLK_W-1:0] CLK_MAX     = 16'hffff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_H_SYNC   = 3'd0,
    REG_H_ACTIVE = 3'd1,
    REG_V_SYNC   = 3'd2,
    REG_V_ACTIVE = 3'd3,
    REG_H_PIXELS = 3'd4,
    REG_V_LINES  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [PCT_W-1:0]    rem;
    logic [D100_BPS-1:0] q;
  } d100_t;

  // Eight restoring steps of a long division by 100; the remainder stays below 100
  function automatic d100_t div100_step(input logic [PCT_W-1:0] rem_in,
                                        input logic [D100_BPS-1:0] bits);
    d100_t res;
    logic [PCT_W:0] t;
    res.rem = rem_in;
    res.q   = '0;
    for (int i = D100_BPS - 1; i >= 0; i--) begin
      t = {res.rem, bits[i]};
      if (t >= {1'b0, PCT_FULL}) begin
        t       = t - {1'b0, PCT_FULL};
        res.q[i] = 1'b1;
      end
      res.rem = t[PCT_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ hdl/vtpc_in_if.sv @@
// Input channel of the prescaler calculator: one measured period per word.
// Depends on vtpc_pkg.
interface vtpc_in_if import vtpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [PERIOD_W-1:0] period;

  modport source (output valid, output mode, output period, input ready);
  modport sink   (input valid, input mode, input period, output ready);
endinterface

@@ hdl/vtpc_out_if.sv @@
// Result channel of the prescaler calculator: one word per accepted period.
// Depends on vtpc_pkg.
interface vtpc_out_if import vtpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              axis;
  logic              updated;
  logic [CNT_W-1:0]  sync_wait_count;
  logic [PRE_W-1:0]  sync_wait_prescale;
  logic [PCLK_W-1:0] pixel_clock_prescale;

  modport source (output valid, output axis, output updated, output sync_wait_count,
                  output sync_wait_prescale, output pixel_clock_prescale, input ready);
  modport sink   (input valid, input axis, input updated, input sync_wait_count,
                  input sync_wait_prescale, input pixel_clock_prescale, output ready);
endinterface

@@ hdl/video_timing_prescaler_calc.sv @@
// Top level of the video timing prescaler calculator: config registers, pipeline
// control and the classify stage. Depends on vtpc_pkg, vtpc_in_if, vtpc_out_if,
// vtpc_div100 and vtpc_resdiv.
//
//   port    | dir | word / fields
//   --------+-----+-----------------------------------------------------------
//   in_ch   | in  | mode, period
//   out_ch  | out | axis, updated, sync_wait_count, sync_wait_prescale,
//           |     | pixel_clock_prescale
//   cfg_*   | in  | cfg_we, cfg_idx, cfg_wdata (write only)
//
// One word per cycle sustained while out_ch.ready is high; the depth is set
// by the five divide-by-100 stages and the eight stages of the resolution divider.
// Each stage holds only when it is full and the stage after it is held, so
// bubbles close up and in_ch.ready stays high while the output register is empty.
// rst_n is synchronous; valid bits and percentages clear, resolutions get MIN_RES.
module video_timing_prescaler_calc import vtpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  vtpc_in_if.sink               in_ch,
  vtpc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ST_IN  = 0;
  localparam int ST_MUL = 1;
  localparam int ST_D0  = 2;
  localparam int ST_CLS = ST_D0 + D100_STG;
  localparam int ST_R0  = ST_CLS + 1;
  localparam int ST_OUT = ST_R0 + RDIV_STG;
  localparam int NSTG   = ST_OUT + 1;

  typedef struct packed {
    logic             mode;
    logic             upd;
    logic             sat;
    logic [RES_W-1:0] res;
    logic [CNT_W-1:0] count;
    logic [PRE_W-1:0] pre;
  } side_t;

  // configuration
  logic [PCT_W-1:0] h_sync_r, h_active_r, v_sync_r, v_active_r;
  logic [RES_W-1:0] h_pixels_r, v_lines_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_sync_r   <= '0;
      h_active_r <= '0;
      v_sync_r   <= '0;
      v_active_r <= '0;
      h_pixels_r <= MIN_RES;
      v_lines_r  <= MIN_RES;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_H_SYNC:   h_sync_r   <= cfg_wdata[PCT_W-1:0];
        REG_H_ACTIVE: h_active_r <= cfg_wdata[PCT_W-1:0];
        REG_V_SYNC:   v_sync_r   <= cfg_wdata[PCT_W-1:0];
        REG_V_ACTIVE: v_active_r <= cfg_wdata[PCT_W-1:0];
        REG_H_PIXELS: h_pixels_r <= cfg_wdata[RES_W-1:0];
        REG_V_LINES:  v_lines_r  <= cfg_wdata[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] rdy;

  // sideband that travels alongside the arithmetic
  side_t side_r   [NSTG];
  side_t side_nxt [NSTG];

  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_ch.ready = rdy[ST_IN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= (k == ST_IN) ? in_ch.valid : vld_r[(k == ST_IN) ? ST_IN : k - 1];
        end
      end
    end
  end

  // input stage: pick the axis and clamp the percentages and resolution
  logic [PCT_W-1:0]       sync_sel, act_sel, sync_c, act_c, act_room;
  logic [RES_W-1:0]       res_sel, res_c;
  logic [PERIOD_BITS-1:0] period_in;

  always_comb begin
    sync_sel  = in_ch.mode ? v_sync_r   : h_sync_r;
    act_sel   = in_ch.mode ? v_active_r : h_active_r;
    res_sel   = in_ch.mode ? v_lines_r  : h_pixels_r;
    sync_c    = (sync_sel > PCT_FULL) ? PCT_FULL : sync_sel;
    act_room  = PCT_FULL - sync_c;
    act_c     = (act_sel > act_room) ? act_room : act_sel;
    res_c     = (res_sel < MIN_RES) ? MIN_RES : res_sel;
    period_in = in_ch.period[PERIOD_BITS-1:0];
  end

  logic [PERIOD_BITS-1:0] period_r;
  logic [PCT_W-1:0]       sync_r, act_pct_r;
  logic [PROD_W-1:0]      wprod_r, aprod_r;

  always_ff @(posedge clk) begin
    if (rdy[ST_IN]) begin
      period_r  <= period_in;
      sync_r    <= sync_c;
      act_pct_r <= act_c;
    end
    if (rdy[ST_MUL]) begin
      wprod_r <= PROD_W'(period_r) * PROD_W'(sync_r);
      aprod_r <= PROD_W'(period_r) * PROD_W'(act_pct_r);
    end
  end

  logic [PERIOD_BITS-1:0] wait_q, act_q;

  vtpc_div100 u_wait_div (
    .clk  (clk),
    .en   (rdy[ST_D0 +: D100_STG]),
    .prod (wprod_r),
    .quot (wait_q)
  );

  vtpc_div100 u_act_div (
    .clk  (clk),
    .en   (rdy[ST_D0 +: D100_STG]),
    .prod (aprod_r),
    .quot (act_q)
  );

  // classify stage: coarse prescaler for the wait, saturation test for the clock
  logic [31:0]      wait32, act32;
  logic             sat_c;
  logic [CNT_W-1:0] count_c;
  logic [PRE_W-1:0] pre_c;
  logic [RES_W-1:0] act_hi_r, act_lo_r;

  always_comb begin
    wait32 = 32'(wait_q);
    act32  = 32'(act_q);
    sat_c  = (act32[31:16] >= side_r[ST_CLS-1].res);
    if (wait32 > MID_LIMIT) begin
      pre_c   = PRE_HIGH;
      count_c = wait32[31:8];
    end else if (wait32 > SMALL_LIMIT) begin
      pre_c   = PRE_MID;
      count_c = wait32[27:4];
    end else begin
      pre_c   = PRE_NONE;
      count_c = wait32[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[ST_CLS]) begin
      // a saturated word still runs through the divider; its quotient is dropped
      act_hi_r <= sat_c ? '0 : act32[31:16];
      act_lo_r <= act32[15:0];
    end
  end

  logic [PCLK_W-1:0] quot_q;

  vtpc_resdiv u_resdiv (
    .clk    (clk),
    .en     (rdy[ST_R0 +: RDIV_STG]),
    .dvd_hi (act_hi_r),
    .dvd_lo (act_lo_r),
    .dvs    (side_r[ST_CLS].res),
    .quot   (quot_q)
  );

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (k == ST_IN) begin
        side_nxt[k] = '{mode: in_ch.mode, upd: (period_in != '0), sat: 1'b0,
                        res: res_c, count: '0, pre: PRE_NONE};
      end else begin
        side_nxt[k] = side_r[(k == ST_IN) ? ST_IN : k - 1];
        if (k == ST_CLS) begin
          side_nxt[k].sat   = sat_c;
          side_nxt[k].count = count_c;
          side_nxt[k].pre   = pre_c;
        end
      end
    end
  end

  logic [PCLK_W-1:0] pclk_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (rdy[k]) begin
        side_r[k] <= side_nxt[k];
      end
    end
    if (rdy[ST_OUT]) begin
      pclk_r <= side_r[ST_OUT-1].sat ? CLK_MAX : quot_q;
    end
  end

  assign out_ch.valid                = vld_r[ST_OUT];
  assign out_ch.axis                 = side_r[ST_OUT].mode;
  assign out_ch.updated              = side_r[ST_OUT].upd;
  assign out_ch.sync_wait_count      = side_r[ST_OUT].count;
  assign out_ch.sync_wait_prescale   = side_r[ST_OUT].pre;
  assign out_ch.pixel_clock_prescale = pclk_r;

  // an empty output register must open the whole pipe
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[ST_OUT] |-> in_ch.ready)
    else $error("input held back while the output register is empty");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> vld_r[ST_IN])
    else $error("accepted word did not reach the input stage");

  a_zero_period_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.updated |->
      out_ch.sync_wait_count == '0 && out_ch.sync_wait_prescale == PRE_NONE &&
      out_ch.pixel_clock_prescale == '0)
    else $error("zero period gave a nonzero result");

  a_prescale_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.sync_wait_prescale == PRE_NONE ||
      out_ch.sync_wait_prescale == PRE_MID || out_ch.sync_wait_prescale == PRE_HIGH)
    else $error("sync wait prescaler outside 0, 15 or 255");

  a_small_wait_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.sync_wait_prescale == PRE_NONE |->
      out_ch.sync_wait_count <= CNT_W'(SMALL_LIMIT))
    else $error("unscaled sync wait above the small limit");

endmodule

@@ hdl/vtpc_div100.sv @@
// Pipelined divide-by-100 lane, eight quotient bits per stage.
// Depends on vtpc_pkg (div100_step, lane widths).
module vtpc_div100 import vtpc_pkg::*; (
  input  logic                   clk,
  input  logic [D100_STG-1:0]    en,
  input  logic [PROD_W-1:0]      prod,
  output logic [PERIOD_BITS-1:0] quot
);

  logic [PCT_W-1:0]  rem_r  [D100_STG];
  logic [D100_W-1:0] word_r [D100_STG];
  logic [PCT_W-1:0]  rem_in  [D100_STG];
  logic [D100_W-1:0] word_in [D100_STG];
  d100_t             step    [D100_STG];

  always_comb begin
    for (int j = 0; j < D100_STG; j++) begin
      if (j == 0) begin
        rem_in[j]  = '0;
        word_in[j] = D100_W'(prod);
      end else begin
        rem_in[j]  = rem_r[j-1];
        word_in[j] = word_r[j-1];
      end
      step[j] = div100_step(rem_in[j], word_in[j][D100_W-1 -: D100_BPS]);
    end
  end

  // dividend bits shift out at the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    for (int j = 0; j < D100_STG; j++) begin
      if (en[j]) begin
        rem_r[j]  <= step[j].rem;
        word_r[j] <= {word_in[j][D100_W-D100_BPS-1:0], step[j].q};
      end
    end
  end

  assign quot = word_r[D100_STG-1][PERIOD_BITS-1:0];

endmodule

@@ hdl/vtpc_resdiv.sv @@
// Pipelined restoring divider for active time over resolution, two bits per stage.
// Caller guarantees the upper half is below the divisor. Depends on vtpc_pkg.
module vtpc_resdiv import vtpc_pkg::*; (
  input  logic                clk,
  input  logic [RDIV_STG-1:0] en,
  input  logic [RES_W-1:0]    dvd_hi,
  input  logic [RES_W-1:0]    dvd_lo,
  input  logic [RES_W-1:0]    dvs,
  output logic [PCLK_W-1:0]   quot
);

  typedef struct packed {
    logic [RES_W-1:0] rem;
    logic [RES_W-1:0] word;
  } rdiv_t;

  function automatic rdiv_t rdiv_step(input rdiv_t cur, input logic [RES_W-1:0] d);
    rdiv_t res;
    logic [RES_W:0] t;
    logic qb;
    res = cur;
    for (int i = 0; i < RDIV_BPS; i++) begin
      t  = {res.rem, res.word[RES_W-1]};
      qb = (t >= {1'b0, d});
      if (qb) begin
        t = t - {1'b0, d};
      end
      res.rem  = t[RES_W-1:0];
      res.word = {res.word[RES_W-2:0], qb};
    end
    return res;
  endfunction

  rdiv_t            st_r   [RDIV_STG];
  logic [RES_W-1:0] dvs_r  [RDIV_STG];
  rdiv_t            st_in  [RDIV_STG];
  logic [RES_W-1:0] dvs_in [RDIV_STG];

  always_comb begin
    for (int j = 0; j < RDIV_STG; j++) begin
      if (j == 0) begin
        st_in[j]  = '{rem: dvd_hi, word: dvd_lo};
        dvs_in[j] = dvs;
      end else begin
        st_in[j]  = st_r[j-1];
        dvs_in[j] = dvs_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < RDIV_STG; j++) begin
      if (en[j]) begin
        st_r[j]  <= rdiv_step(st_in[j], dvs_in[j]);
        dvs_r[j] <= dvs_in[j];
      end
    end
  end

  assign quot = PCLK_W'(st_r[RDIV_STG-1].word);

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for video_timing_prescaler_calc: a directed table, then random
// phases under random stalls, each result word checked against the table or an in-bench model.
// Depends on vtpc_pkg, vtpc_in_if, vtpc_out_if and the block itself.
module tb_top import vtpc_pkg::*; ();

  localparam int CLK_HALF    = 6;
  localparam int RST_CYCLES  = 7;
  localparam int SETTLE      = 24;    // a little over the pipeline latency
  // longest quiet stretch of a good run: HOLD_LEN hold-off plus the longest gap plus latency
  localparam int IDLE_LIMIT  = 3000;
  localparam int N_PHASES    = 8;
  localparam int PHASE_WORDS = 50;
  localparam int BURST_PHASE = 1;
  localparam int HOLD_PHASE  = 2;
  localparam int PAUSE_PHASE = 5;
  localparam int HOLD_LEN    = 150;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

  typedef struct packed {
    logic              axis;
    logic              updated;
    logic [CNT_W-1:0]  count;
    logic [PRE_W-1:0]  pre;
    logic [PCLK_W-1:0] pclk;
  } timing_t;

  typedef struct packed {
    logic                  typed;
    timing_t               res;
  } tag_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  mode;
    logic [PERIOD_W-1:0]   period;
    logic                  typed;
    timing_t               res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  vtpc_in_if  in_ch ();
  vtpc_out_if out_ch ();

  video_timing_prescaler_calc dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the timing registers
  logic [PCT_W-1:0] h_sync_pct, h_act_pct, v_sync_pct, v_act_pct;
  logic [RES_W-1:0] h_res, v_res;

  timing_t     timing_q [$];
  tag_t        tag_q [$];
  stim_row_t   dir_tbl [$];
  int unsigned words_sent = 0;
  int unsigned words_got  = 0;
  int unsigned n_fail     = 0;
  int unsigned idle_cycles = 0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  function automatic timing_t predict_timing(input logic mode,
                                             input logic [PERIOD_W-1:0] period);
    logic [PCT_W-1:0] sync_pct, act_pct;
    logic [RES_W-1:0] res;
    logic [63:0]      ticks, sync_ticks, act_ticks, per_pixel;
    timing_t          r;
    ticks    = 64'(period) & ((64'd1 << PERIOD_BITS) - 64'd1);
    sync_pct = mode ? v_sync_pct : h_sync_pct;
    act_pct  = mode ? v_act_pct : h_act_pct;
    res      = mode ? v_res : h_res;
    if (sync_pct > PCT_FULL) sync_pct = PCT_FULL;
    if (act_pct > PCT_FULL - sync_pct) act_pct = PCT_FULL - sync_pct;
    if (res < MIN_RES) res = MIN_RES;
    r         = '0;
    r.axis    = mode;
    r.updated = (ticks != 0);
    if (ticks != 0) begin
      // full-width products, no wrap
      sync_ticks = ticks * 64'(sync_pct) / 64'(PCT_FULL);
      act_ticks  = ticks * 64'(act_pct) / 64'(PCT_FULL);
      if (sync_ticks > 64'(MID_LIMIT)) begin
        r.pre   = PRE_HIGH;
        r.count = CNT_W'(sync_ticks >> 8);
      end else if (sync_ticks > 64'(SMALL_LIMIT)) begin
        r.pre   = PRE_MID;
        r.count = CNT_W'(sync_ticks >> 4);
      end else begin
        r.pre   = PRE_NONE;
        r.count = CNT_W'(sync_ticks);
      end
      per_pixel = act_ticks / 64'(res);
      r.pclk    = (per_pixel > 64'(CLK_MAX)) ? CLK_MAX : PCLK_W'(per_pixel);
    end
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic stim_row_t item_row(input logic mode, input logic [PERIOD_W-1:0] period);
    stim_row_t r;
    r        = '0;
    r.mode   = mode;
    r.period = period;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic mode, input logic [PERIOD_W-1:0] period,
                                          input logic updated, input logic [CNT_W-1:0] count,
                                          input logic [PRE_W-1:0] pre,
                                          input logic [PCLK_W-1:0] pclk);
    stim_row_t r;
    r       = item_row(mode, period);
    r.typed = 1'b1;
    r.res   = timing_t'{mode, updated, count, pre, pclk};
    return r;
  endfunction

  // mostly back-to-back, now and then a long gap
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 60);
  endfunction

  function automatic int unsigned run_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(40, 120);
    return $urandom_range(1, 12);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_pct();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CFG_DATA_W'(PCT_FULL);
      2:       return CFG_DATA_W'($urandom_range(101, 127));
      3:       return CFG_DATA_W'($urandom);   // upper bits must be dropped
      default: return CFG_DATA_W'($urandom_range(0, 100));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_res();
    case ($urandom_range(0, 9))
      0:       return CFG_DATA_W'($urandom_range(0, 31));
      1:       return CFG_DATA_W'(MIN_RES);
      2:       return '1;
      3:       return CFG_DATA_W'($urandom_range(33, 300));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [PERIOD_W-1:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PERIOD_W'($urandom_range(1, 4000));
      2:       return PERIOD_W'($urandom_range(32'h0001_0000, 32'h0040_0000));
      3:       return ~PERIOD_W'($urandom_range(0, 255));
      4:       return PERIOD_W'(1) << $urandom_range(0, PERIOD_W - 1);
      default: return PERIOD_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic send_word(input logic mode, input logic [PERIOD_W-1:0] period,
                           input tag_t tag, input bit no_gap);
    int unsigned gap;
    tag_q.push_back(tag);
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= mode;
    in_ch.period <= period;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    words_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for every outstanding result, then let the pipe empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (words_got != words_sent) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      n_fail++;
      $display("%0t: %s expected 'h%0h got 'h%0h", $time, name, want, got);
    end
  endtask

  // shadow registers and the expected-result store
  always @(posedge clk) begin : timing_mon
    tag_t tag;
    if (!rst_n) begin
      h_sync_pct = '0;
      h_act_pct  = '0;
      v_sync_pct = '0;
      v_act_pct  = '0;
      h_res      = MIN_RES;
      v_res      = MIN_RES;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_H_SYNC:   h_sync_pct = cfg_wdata[PCT_W-1:0];
          REG_H_ACTIVE: h_act_pct  = cfg_wdata[PCT_W-1:0];
          REG_V_SYNC:   v_sync_pct = cfg_wdata[PCT_W-1:0];
          REG_V_ACTIVE: v_act_pct  = cfg_wdata[PCT_W-1:0];
          REG_H_PIXELS: h_res      = cfg_wdata[RES_W-1:0];
          REG_V_LINES:  v_res      = cfg_wdata[RES_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        tag = (tag_q.size() != 0) ? tag_q.pop_front() : '0;
        timing_q.push_back(tag.typed ? tag.res : predict_timing(in_ch.mode, in_ch.period));
      end
    end
  end

  always @(posedge clk) begin : timing_chk
    timing_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_got++;
      if (timing_q.size() == 0) begin
        n_fail++;
        $display("%0t: result word with none expected, axis %0b", $time, out_ch.axis);
      end else begin
        want = timing_q.pop_front();
        check_field("axis", 32'(want.axis), 32'(out_ch.axis));
        check_field("updated", 32'(want.updated), 32'(out_ch.updated));
        check_field("sync_wait_count", 32'(want.count), 32'(out_ch.sync_wait_count));
        check_field("sync_wait_prescale", 32'(want.pre), 32'(out_ch.sync_wait_prescale));
        check_field("pixel_clock_prescale", 32'(want.pclk), 32'(out_ch.pixel_clock_prescale));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("video_timing_prescaler_calc: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random on/off runs, plus one long hold-off on request
  initial begin : result_sink
    int unsigned left;
    bit          on;
    left = 0;
    on   = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        on        = 1'b0;
        left      = HOLD_LEN;
      end else if (left > 1) begin
        left--;
      end else begin
        on   = !on;
        left = on ? run_len() : pick_gap();
        if (left == 0) begin
          on   = 1'b1;
          left = run_len();
        end
      end
      out_ch.ready <= on;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    bit        in_cfg;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = 1'b0;
    in_ch.period = '0;

    dir_tbl = '{
      // reset values: no sync, no active share
      typed_row(1'b0, 32'd0, 1'b0, '0, PRE_NONE, '0),
      typed_row(1'b1, 32'hffff_ffff, 1'b1, '0, PRE_NONE, '0),
      // full sync on both axes, active clamped to nothing, resolution 0 and max
      cfg_row(REG_H_SYNC, 16'd100),
      cfg_row(REG_H_ACTIVE, 16'd100),
      cfg_row(REG_V_SYNC, 16'd127),
      cfg_row(REG_V_ACTIVE, 16'd127),
      cfg_row(REG_H_PIXELS, 16'd0),
      cfg_row(REG_V_LINES, 16'hffff),
      typed_row(1'b0, 32'hffff_ffff, 1'b1, 24'hff_ffff, PRE_HIGH, '0),
      typed_row(1'b1, 32'hffff_ffff, 1'b1, 24'hff_ffff, PRE_HIGH, '0),
      typed_row(1'b0, 32'd1, 1'b1, 24'd1, PRE_NONE, '0),
      // prescale boundaries either side
      typed_row(1'b0, 32'h0000_ffff, 1'b1, 24'h00_ffff, PRE_NONE, '0),
      typed_row(1'b0, 32'h0001_0000, 1'b1, 24'h00_1000, PRE_MID, '0),
      typed_row(1'b0, 32'h000f_ffff, 1'b1, 24'h00_ffff, PRE_MID, '0),
      typed_row(1'b0, 32'h0010_0000, 1'b1, 24'h00_1000, PRE_HIGH, '0),
      typed_row(1'b1, 32'd0, 1'b0, '0, PRE_NONE, '0),
      // all active, resolution below the floor: pixel clock saturates
      cfg_row(REG_H_SYNC, 16'd0),
      cfg_row(REG_H_ACTIVE, 16'd100),
      cfg_row(REG_H_PIXELS, 16'd31),
      typed_row(1'b0, 32'hffff_ffff, 1'b1, '0, PRE_NONE, CLK_MAX),
      item_row(1'b0, 32'd100),
      item_row(1'b0, 32'd31),
      // masked percent, the widest divisor, writes to unused indexes
      cfg_row(REG_H_SYNC, 16'hff80),
      cfg_row(REG_H_PIXELS, 16'hffff),
      cfg_row(REG_V_SYNC, 16'd1),
      cfg_row(REG_V_ACTIVE, 16'd99),
      cfg_row(REG_V_LINES, 16'd1000),
      cfg_row(REG_SPARE6, 16'hffff),
      cfg_row(REG_SPARE7, 16'h5a5a),
      item_row(1'b0, 32'hffff_ffff),
      item_row(1'b1, 32'hffff_ffff),
      item_row(1'b1, 32'd12345678),
      item_row(1'b0, 32'h8000_0000),
      item_row(1'b1, 32'd1),
      // active above 100 minus sync
      cfg_row(REG_H_SYNC, 16'd30),
      cfg_row(REG_H_ACTIVE, 16'd80),
      cfg_row(REG_H_PIXELS, 16'd32),
      item_row(1'b0, 32'h0000_ffff),
      item_row(1'b0, 32'h7fff_ffff),
      item_row(1'b0, 32'h5555_5555),
      item_row(1'b1, 32'haaaa_aaaa)
    };

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    in_cfg = 1'b0;
    foreach (dir_tbl[k]) begin
      row = dir_tbl[k];
      if (row.is_cfg) begin
        if (!in_cfg) begin
          drain();
          in_cfg = 1'b1;
        end
        write_reg(row.idx, row.data);
      end else begin
        if (in_cfg) begin
          cfg_we <= 1'b0;
          in_cfg = 1'b0;
        end
        send_word(row.mode, row.period, tag_t'{row.typed, row.res}, 1'b0);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_reg(REG_H_SYNC, rand_pct());
      write_reg(REG_H_ACTIVE, rand_pct());
      write_reg(REG_V_SYNC, rand_pct());
      write_reg(REG_V_ACTIVE, rand_pct());
      write_reg(REG_H_PIXELS, rand_res());
      write_reg(REG_V_LINES, rand_res());
      if ($urandom_range(0, 1) != 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, CFG_DATA_W'($urandom));
      cfg_we <= 1'b0;
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == PAUSE_PHASE && i == PHASE_WORDS / 2) drain();
        send_word(1'($urandom_range(0, 1)), rand_period(), '0, p == BURST_PHASE);
      end
    end

    drain();
    if (timing_q.size() != 0)
      $display("%0t: %0d expected words never arrived", $time, timing_q.size());
    if (n_fail == 0 && timing_q.size() == 0) begin
      $display("video_timing_prescaler_calc: match");
    end else begin
      $display("video_timing_prescaler_calc: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/vtpc_pkg.sv
hdl/vtpc_in_if.sv
hdl/vtpc_out_if.sv
hdl/vtpc_div100.sv
hdl/vtpc_resdiv.sv
hdl/video_timing_prescaler_calc.sv
tb/tb_top.sv
